/* rtl/assert_macros.svh */
// Assertion macros shared by the line rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BRL_ASSERT(lbl, c, r, p) lbl: assert property (@(posedge c) disable iff (r) (p)) \
  else $error("assertion failed");
`define BRL_NEVER(lbl, c, r, p) lbl: assert property (@(posedge c) disable iff (r) !(p)) \
  else $error("forbidden condition seen");
`else
`define BRL_ASSERT(lbl, c, r, p)
`define BRL_NEVER(lbl, c, r, p)
`endif
`endif

/* rtl/brl_pkg.sv */
// Shared types and constants of the line rasterizer.
package brl_pkg;
  localparam int MaxDim    = 4096;
  localparam int FracBits  = 16;
  localparam int PosW      = FracBits + 1;
  localparam int CoordW    = 12;
  localparam int SizeW     = 13;
  localparam int LenW      = 2 * CoordW + 1;
  localparam int NumW      = LenW + 2 * FracBits;
  localparam int QuotW     = 2 * FracBits + 1;
  localparam int SqrtSteps = (QuotW + 1) / 2;
  localparam logic [PosW-1:0]  PosOne  = PosW'(1) << FracBits;
  localparam logic [SizeW-1:0] SizeMax = SizeW'(MaxDim);

  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;
  localparam logic FuncLoad       = 1'b0;

  typedef struct packed {
    logic       latch_load;
    logic       scale_en;
    logic [1:0] scale_idx;
    logic       setup;
    logic       len;
    logic       sq;
    logic       sum;
    logic       div_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       frac_zero;
    logic       frac_take;
    logic       advance;
  } brl_cmd_t;

  typedef struct packed {
    logic active;
    logic total_zero;
  } brl_status_t;
endpackage

/* rtl/brl_if.sv */
// Handshake channels of the line rasterizer: line items in, pixels out.
interface brl_in_if;
  import brl_pkg::*;
  logic            valid;
  logic            ready;
  logic            func;
  logic [PosW-1:0] start_pos_x;
  logic [PosW-1:0] start_pos_y;
  logic [PosW-1:0] end_pos_x;
  logic [PosW-1:0] end_pos_y;
  modport source (output valid, func, start_pos_x, start_pos_y, end_pos_x, end_pos_y,
                  input ready);
  modport sink (input valid, func, start_pos_x, start_pos_y, end_pos_x, end_pos_y,
                output ready);
endinterface

interface brl_out_if;
  import brl_pkg::*;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] pixel_x;
  logic [CoordW-1:0] pixel_y;
  logic [PosW-1:0]   fraction;
  logic              last;
  modport source (output valid, pixel_x, pixel_y, fraction, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, fraction, last, output ready);
endinterface

/* rtl/brl_ctrl.sv */
// Sequencer of the line rasterizer: steps the datapath through load and pixel work.
module brl_ctrl
  import brl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_func,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  brl_status_t status,
  output brl_cmd_t    cmd
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCALE = 10'b0000000010,
    S_SETUP = 10'b0000000100,
    S_LEN   = 10'b0000001000,
    S_SQ    = 10'b0000010000,
    S_SUM   = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_SQI   = 10'b0010000000,
    S_SQRT  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t     state, state_next;
  logic [5:0] cnt, cnt_next;
  logic       in_fire;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.scale_idx = cnt[1:0];
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_fire) begin
          if (in_func == FuncLoad) begin
            cmd.latch_load = 1'b1;
            state_next = S_SCALE;
          end else if (status.active) begin
            state_next = S_SQ;
          end
        end
      end
      S_SCALE: begin
        cmd.scale_en = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd3) state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_next = S_LEN;
      end
      S_LEN: begin
        cmd.len = 1'b1;
        state_next = S_IDLE;
      end
      S_SQ: begin
        cmd.sq = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        cnt_next = '0;
        if (status.total_zero) begin
          cmd.frac_zero = 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(NumW - 1)) state_next = S_SQI;
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_next = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(SqrtSteps - 1)) state_next = S_OUT;
      end
      S_OUT: begin
        if (cnt == 6'(SqrtSteps)) cmd.frac_take = 1'b1;
        cnt_next = '0;
        if (out_ready) begin
          cmd.advance = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end
endmodule

/* rtl/brl_dp.sv */
// Datapath of the line rasterizer: scaling, error walk, divider and square root.
module brl_dp
  import brl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SizeW-1:0]  cfg_data,
  input  logic [PosW-1:0]   start_pos_x,
  input  logic [PosW-1:0]   start_pos_y,
  input  logic [PosW-1:0]   end_pos_x,
  input  logic [PosW-1:0]   end_pos_y,
  input  brl_cmd_t          cmd,
  output brl_status_t       status,
  output logic [CoordW-1:0] pixel_x,
  output logic [CoordW-1:0] pixel_y,
  output logic [PosW-1:0]   fraction,
  output logic              last
);
  logic [SizeW-1:0]    frame_width, frame_height;
  logic [PosW-1:0]     pos [4];
  logic [CoordW-1:0]   sc [4];
  logic                active;
  logic [CoordW-1:0]   cur_x, cur_y, origin_x, origin_y, target_x, target_y;
  logic [CoordW-1:0]   abs_delta_x;
  logic signed [12:0]  neg_abs_delta_y;
  logic                dir_x_neg, dir_y_neg;
  logic signed [13:0]  walk_error;
  logic [LenW-1:0]     total_len_sq;
  logic [2*CoordW-1:0] sqa, sqb;
  logic [NumW-1:0]     num;
  logic [LenW-1:0]     rem;
  logic [QuotW-1:0]    quot;
  logic [QuotW:0]      sv;
  logic [SqrtSteps-1:0] sroot;
  logic [SqrtSteps+2:0] srem;
  logic [PosW-1:0]     frac;

  function automatic logic [PosW-1:0] clamp_pos(input logic [PosW-1:0] p);
    return (p > PosOne) ? PosOne : p;
  endfunction

  // Scaling: one shared multiplier, one endpoint coordinate per cycle.
  logic [SizeW-1:0]      size_raw, size_cl;
  logic [CoordW-1:0]     size_m1;
  logic [PosW+CoordW-1:0] scale_prod;
  always_comb begin
    size_raw = cmd.scale_idx[0] ? frame_height : frame_width;
    if (size_raw == '0) size_cl = SizeW'(1);
    else if (size_raw > SizeMax) size_cl = SizeMax;
    else size_cl = size_raw;
    size_m1 = CoordW'(size_cl - SizeW'(1));
    scale_prod = pos[cmd.scale_idx] * size_m1;
  end

  // Setup and per-pixel distance terms.
  logic [CoordW-1:0] ax, ay, ddx, ddy;
  always_comb begin
    ax  = (sc[2] > sc[0]) ? sc[2] - sc[0] : sc[0] - sc[2];
    ay  = (sc[3] > sc[1]) ? sc[3] - sc[1] : sc[1] - sc[3];
    ddx = (cur_x > origin_x) ? cur_x - origin_x : origin_x - cur_x;
    ddy = (cur_y > origin_y) ? cur_y - origin_y : origin_y - cur_y;
  end

  // Division step and square root step.
  logic [LenW:0]        dtrial;
  logic                 dge;
  logic [SqrtSteps+2:0] strial_rem, strial;
  logic                 sge;
  always_comb begin
    dtrial     = {rem, num[NumW-1]};
    dge        = dtrial >= {1'b0, total_len_sq};
    strial_rem = {srem[SqrtSteps:0], sv[QuotW:QuotW-1]};
    strial     = {1'b0, sroot, 2'b01};
    sge        = strial_rem >= strial;
  end

  // Error walk.
  logic signed [14:0] e2;
  logic signed [13:0] err_a;
  logic               step_x, step_y;
  always_comb begin
    e2     = {walk_error, 1'b0};
    step_x = e2 >= 15'(neg_abs_delta_y);
    step_y = e2 <= $signed({3'b000, abs_delta_x});
    err_a  = walk_error + (step_x ? 14'(neg_abs_delta_y) : 14'sd0)
                        + (step_y ? $signed({2'b00, abs_delta_x}) : 14'sd0);
  end

  assign last = (cur_x == target_x) && (cur_y == target_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= SizeW'(640);
      frame_height <= SizeW'(480);
      active       <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == RegFrameWidth) frame_width <= cfg_data;
      if (cfg_we && cfg_index == RegFrameHeight) frame_height <= cfg_data;
      if (cmd.setup) active <= 1'b1;
      if (cmd.advance && last) active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_load) begin
      pos[0] <= clamp_pos(start_pos_x);
      pos[1] <= clamp_pos(start_pos_y);
      pos[2] <= clamp_pos(end_pos_x);
      pos[3] <= clamp_pos(end_pos_y);
    end
    if (cmd.scale_en) sc[cmd.scale_idx] <= scale_prod[FracBits +: CoordW];
    if (cmd.setup) begin
      origin_x <= sc[0];  origin_y <= sc[1];
      cur_x    <= sc[0];  cur_y    <= sc[1];
      target_x <= sc[2];  target_y <= sc[3];
      abs_delta_x     <= ax;
      neg_abs_delta_y <= -$signed({1'b0, ay});
      dir_x_neg  <= !(sc[0] < sc[2]);
      dir_y_neg  <= !(sc[1] < sc[3]);
      walk_error <= $signed({2'b00, ax}) - $signed({2'b00, ay});
      sqa <= ax * ax;
      sqb <= ay * ay;
    end
    if (cmd.len) total_len_sq <= LenW'(sqa) + LenW'(sqb);
    if (cmd.sq) begin
      sqa <= ddx * ddx;
      sqb <= ddy * ddy;
    end
    if (cmd.sum) begin
      num  <= {LenW'(sqa) + LenW'(sqb), (2*FracBits)'(0)};
      rem  <= '0;
      quot <= '0;
    end
    if (cmd.div_step) begin
      rem  <= dge ? LenW'(dtrial - {1'b0, total_len_sq}) : LenW'(dtrial);
      num  <= {num[NumW-2:0], 1'b0};
      quot <= {quot[QuotW-2:0], dge};
    end
    if (cmd.sqrt_init) begin
      sv    <= {1'b0, quot};
      srem  <= '0;
      sroot <= '0;
    end
    if (cmd.sqrt_step) begin
      srem  <= sge ? strial_rem - strial : strial_rem;
      sroot <= {sroot[SqrtSteps-2:0], sge};
      sv    <= {sv[QuotW-2:0], 2'b00};
    end
    if (cmd.frac_zero) frac <= '0;
    if (cmd.frac_take) frac <= (PosW'(sroot) > PosOne) ? PosOne : PosW'(sroot);
    if (cmd.advance && !last) begin
      walk_error <= err_a;
      if (step_x) cur_x <= dir_x_neg ? cur_x - CoordW'(1) : cur_x + CoordW'(1);
      if (step_y) cur_y <= dir_y_neg ? cur_y - CoordW'(1) : cur_y + CoordW'(1);
    end
  end

  assign status.active     = active;
  assign status.total_zero = (total_len_sq == '0);
  assign pixel_x  = cur_x;
  assign pixel_y  = cur_y;
  assign fraction = (cmd.frac_take) ? ((PosW'(sroot) > PosOne) ? PosOne : PosW'(sroot)) : frac;
endmodule

/* rtl/bresenham_line_rasterizer_unit.sv */
// A load beat scales the four endpoint coordinates, then runs setup and the line length.
// A step beat squares and sums the distance terms and, for a line of more than one pixel,
// runs the bit-serial divider (57 bits) and square root (17 bits), which set the step rate.
// One beat at a time. A step beat while no line is active is taken and gives no pixel.
// Reset (rst, synchronous, active high) clears the sequencer and the active flag and sets
// the frame size to 640 by 480.
`include "assert_macros.svh"
module bresenham_line_rasterizer_unit
  import brl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [SizeW-1:0] cfg_data,
  brl_in_if.sink           line_in,
  brl_out_if.source        pix_out
);
  brl_cmd_t    cmd;
  brl_status_t status;

  // The sequencer owns the handshakes; the datapath only follows its commands.
  brl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (line_in.valid),
    .in_func   (line_in.func),
    .in_ready  (line_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Scaling, error walk and the distance fraction units live here.
  brl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start_pos_x (line_in.start_pos_x),
    .start_pos_y (line_in.start_pos_y),
    .end_pos_x   (line_in.end_pos_x),
    .end_pos_y   (line_in.end_pos_y),
    .cmd         (cmd),
    .status      (status),
    .pixel_x     (pix_out.pixel_x),
    .pixel_y     (pix_out.pixel_y),
    .fraction    (pix_out.fraction),
    .last        (pix_out.last)
  );

  // A pixel waiting at the output means no new beat may enter.
  `BRL_NEVER(a_no_overlap, clk, rst, pix_out.valid && line_in.ready)
  // The fraction never exceeds one.
  `BRL_ASSERT(a_frac_range, clk, rst, !pix_out.valid || (pix_out.fraction <= PosOne))
  // A pixel beat only comes out while a line is active.
  `BRL_ASSERT(a_active_out, clk, rst, !pix_out.valid || status.active)
  // Delivering the last pixel ends the line.
  `BRL_ASSERT(a_last_ends, clk, rst,
    (pix_out.valid && pix_out.ready && pix_out.last) |=> !status.active)
endmodule
